// ----- design/alsfe_pkg.sv -----
// shared constants, types and helpers for the addressable led spi frame encoder
// no dependencies; imported by every module of the block but the ram
package alsfe_pkg;

  localparam int unsigned LED_MAX     = 64;
  localparam int unsigned RESET_SLOTS = 15;
  localparam int unsigned FRAME_WORDS = 13;

  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned LED_INDEX_W = 6;
  localparam int unsigned SPI_WORD_W  = 16;

  localparam int unsigned ADDR_W    = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;
  localparam int unsigned SLOT_W    = $clog2(LED_MAX + RESET_SLOTS);
  localparam int unsigned WCNT_W    = $clog2(FRAME_WORDS);
  localparam int unsigned IDX_CMP_W = ((LED_INDEX_W > ADDR_W) ? LED_INDEX_W : ADDR_W) + 1;

  localparam logic [SLOT_W-1:0]    SLOT_TOP  = SLOT_W'(LED_MAX + RESET_SLOTS - 1);
  localparam logic [SLOT_W-1:0]    SLOT_LED  = SLOT_W'(LED_MAX);
  localparam logic [IDX_CMP_W-1:0] IDX_LIMIT = IDX_CMP_W'(LED_MAX);
  localparam logic [WCNT_W-1:0]    LAST_WORD = WCNT_W'(FRAME_WORDS - 1);

  localparam logic [7:0] BYTE_ZERO = 8'hC0;
  localparam logic [7:0] BYTE_ONE  = 8'hF0;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_REFILL = 1'b1
  } req_type_e;

  // frame handed from the store read stage to the serialiser
  typedef struct packed {
    logic               is_reset;
    logic [COLOR_W-1:0] grb;
  } frame_t;

  function automatic logic [COLOR_W-1:0] rgb_to_grb(input logic [COLOR_W-1:0] rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

  function automatic logic [7:0] enc_bit(input logic b);
    return b ? BYTE_ONE : BYTE_ZERO;
  endfunction

endpackage

// ----- design/alsfe_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module alsfe_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/alsfe_frame_ser.sv -----
// frame serialiser: turns one grb colour into the words of a spi frame
// and holds each word in the output register; depends on alsfe_pkg
module alsfe_frame_ser import alsfe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ld_valid_i,
  input  frame_t                frame_i,
  output logic                  ld_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SPI_WORD_W-1:0] spi_word_o,
  output logic                  word_last_o,
  output logic                  reset_slot_o
);

  logic               busy_q;
  logic [WCNT_W-1:0]  cnt_q;
  logic [COLOR_W-1:0] grb_q;
  logic               rst_slot_q;

  logic                  out_vld_q;
  logic [SPI_WORD_W-1:0] word_q;
  logic                  last_q;
  logic                  rs_q;

  logic                  out_ready;
  logic                  emit;
  logic                  done;
  logic                  is_last;
  logic [SPI_WORD_W-1:0] word_d;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign emit      = busy_q && out_ready;
  assign is_last   = (cnt_q == LAST_WORD);
  assign done      = emit && is_last;
  assign ld_o      = ld_valid_i && (!busy_q || done);

  // earlier bit of the pair goes in the high byte; closing and reset-slot words are zero
  assign word_d = (rst_slot_q || is_last) ? '0 :
                  {enc_bit(grb_q[COLOR_W-1]), enc_bit(grb_q[COLOR_W-2])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ld_o) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (emit) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_o) begin
      grb_q      <= frame_i.grb;
      rst_slot_q <= frame_i.is_reset;
    end else if (emit) begin
      grb_q <= {grb_q[COLOR_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_q <= word_d;
      last_q <= is_last;
      rs_q   <= rst_slot_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign spi_word_o   = word_q;
  assign word_last_o  = last_q;
  assign reset_slot_o = rs_q;

endmodule

// ----- design/addressable_led_spi_frame_encoder.sv -----
// addressable led spi frame encoder: colour store, slot counter and frame output
// depends on alsfe_pkg, alsfe_ram and alsfe_frame_ser
//
// input channel: one word per accepted item. req_type 0 stores color (rgb) at
// led_index and gives no output; req_type 1 asks for the next spi frame.
// output channel: 13 words per frame, word_last on the thirteenth; reset_slot
// marks the all-zero frames that open each refresh cycle.
// a refill leaves its first word on the output after the store read, serialiser
// load and output register stages, then one word per cycle while the receiver
// does not stall; back-to-back refills stream with no gap between frames, as the
// serialiser loads the next frame as it emits the closing word. writes may follow in
// every cycle during a frame, unless a refill waits in the input register.
// after reset the store reads as all black (one valid flag per led) and the
// slot counter starts at the top: the first reset-slot frames, then leds from
// the highest index down to 0, then round again.
// when the receiver stalls, the output word holds, the serialiser and store
// read stage fill up and in_stall_o rises with an item waiting in the input
// register; nothing is dropped.
module addressable_led_spi_frame_encoder import alsfe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [LED_INDEX_W-1:0] led_index_i,
  input  logic [COLOR_W-1:0]     color_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SPI_WORD_W-1:0]  spi_word_o,
  output logic                   word_last_o,
  output logic                   reset_slot_o
);

  // input register
  logic                   in_vld_q;
  req_type_e              req_q;
  logic [LED_INDEX_W-1:0] idx_q;
  logic [COLOR_W-1:0]     col_q;

  // store read stage
  logic rd_vld_q;
  logic rd_reset_q;
  logic rd_hit_q;

  logic [SLOT_W-1:0]  slot_q;
  logic [LED_MAX-1:0] written_q;

  logic                 in_accept;
  logic                 s1_fire;
  logic                 rd_free;
  logic                 rd_fire;
  logic                 ser_ld;
  logic                 slot_is_reset;
  logic                 wr_en;
  logic                 re;
  logic [IDX_CMP_W-1:0] idx_ext;
  logic [ADDR_W-1:0]    waddr;
  logic [ADDR_W-1:0]    raddr;
  logic [COLOR_W-1:0]   rdata;
  frame_t               frame;

  assign rd_free    = !rd_vld_q || ser_ld;
  assign s1_fire    = in_vld_q && ((req_q == REQ_WRITE) || rd_free);
  assign in_stall_o = in_vld_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign idx_ext = IDX_CMP_W'(idx_q);
  assign waddr   = idx_ext[ADDR_W-1:0];
  assign wr_en   = s1_fire && (req_q == REQ_WRITE) && (idx_ext < IDX_LIMIT);

  assign slot_is_reset = (slot_q >= SLOT_LED);
  assign raddr         = slot_q[ADDR_W-1:0];
  assign rd_fire       = s1_fire && (req_q == REQ_REFILL);
  assign re            = rd_fire && !slot_is_reset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (s1_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_type_e'(req_type_i);
      idx_q <= led_index_i;
      col_q <= color_i;
    end
  end

  // a never-written led reads as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_TOP;
    end else if (rd_fire) begin
      if (slot_q == '0) begin
        slot_q <= SLOT_TOP;
      end else begin
        slot_q <= slot_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_fire) begin
      rd_vld_q <= 1'b1;
    end else if (ser_ld) begin
      rd_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      rd_reset_q <= slot_is_reset;
      rd_hit_q   <= !slot_is_reset && written_q[raddr];
    end
  end

  alsfe_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (LED_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (col_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign frame.is_reset = rd_reset_q;
  assign frame.grb      = rd_hit_q ? rgb_to_grb(rdata) : '0;

  alsfe_frame_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ld_valid_i   (rd_vld_q),
    .frame_i      (frame),
    .ld_o         (ser_ld),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .spi_word_o   (spi_word_o),
    .word_last_o  (word_last_o),
    .reset_slot_o (reset_slot_o)
  );

  // slot counter never leaves its range
  assert property (@(posedge clk_i) disable iff (!rst_ni) slot_q <= SLOT_TOP)
    else $error("slot counter above top");

  // input register only stalls while it holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> in_vld_q)
    else $error("stall with empty input register");

  // closing word and reset-slot words are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (word_last_o || reset_slot_o)) |-> (spi_word_o == '0))
    else $error("non-zero closing or reset-slot word");

  // data words carry only encoded bit bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !word_last_o && !reset_slot_o) |->
      ((spi_word_o[15:8] == BYTE_ZERO || spi_word_o[15:8] == BYTE_ONE) &&
       (spi_word_o[7:0] == BYTE_ZERO || spi_word_o[7:0] == BYTE_ONE)))
    else $error("bad encoded byte");

endmodule

// ----- verif/alsfe_frame_checker.sv -----
// frame checker for the addressable led spi frame encoder
// depends on alsfe_pkg; watches both channels, predicts every spi word and compares
`timescale 1ns / 1ps

module alsfe_frame_checker import alsfe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [LED_INDEX_W-1:0] led_index_i,
  input  logic [COLOR_W-1:0]     color_i,
  input  logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic [SPI_WORD_W-1:0]  spi_word_o,
  input  logic                   word_last_o,
  input  logic                   reset_slot_o,
  output int unsigned            mismatch_cnt_o,
  output int unsigned            words_due_o
);

  localparam int unsigned SLOT_HIGH = LED_MAX + RESET_SLOTS - 1;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [SPI_WORD_W-1:0] word;
    logic                  last;
    logic                  blank;
  } spi_word_t;

  spi_word_t        words_due[$];
  logic [COLOR_W-1:0] colour_store [LED_MAX];
  logic [6:0]       frame_slot;

  // two colour bits become two bytes, the earlier bit in the high byte
  function automatic logic [SPI_WORD_W-1:0] encode_bit_pair(input logic [1:0] pair);
    return {(pair[1] ? BYTE_ONE : BYTE_ZERO), (pair[0] ? BYTE_ONE : BYTE_ZERO)};
  endfunction

  task automatic queue_frame();
    logic [COLOR_W-1:0] rgb;
    logic [COLOR_W-1:0] grb;
    logic               blank;
    spi_word_t          w;
    blank = (frame_slot >= LED_MAX);
    grb   = '0;
    if (!blank) begin
      rgb = colour_store[frame_slot[ADDR_W-1:0]];
      grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
    end
    for (int i = 0; i < FRAME_WORDS; i++) begin
      w.word  = (blank || i == FRAME_WORDS - 1) ? '0 : encode_bit_pair(grb[23 - 2 * i -: 2]);
      w.last  = (i == FRAME_WORDS - 1);
      w.blank = blank;
      words_due.push_back(w);
    end
    // reset slots count down into the leds, led 0 wraps back to the top
    if (!blank && frame_slot == 0) frame_slot = 7'(SLOT_HIGH);
    else frame_slot = frame_slot - 7'd1;
  endtask

  task automatic note_mismatch(input spi_word_t want, input logic missing);
    mismatch_cnt_o = mismatch_cnt_o + 1;
    if (mismatch_cnt_o <= REPORT_MAX) begin
      if (missing)
        $display("[%0t] unexpected word: spi_word=%h last=%b reset_slot=%b",
                 $realtime, spi_word_o, word_last_o, reset_slot_o);
      else
        $display("[%0t] word mismatch: expected %h/%b/%b, got %h/%b/%b", $realtime,
                 want.word, want.last, want.blank, spi_word_o, word_last_o, reset_slot_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spi_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < LED_MAX; i++) colour_store[i] = '0;
      frame_slot     = 7'(SLOT_HIGH);
      words_due.delete();
      mismatch_cnt_o = 0;
      words_due_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (req_type_i == REQ_REFILL) queue_frame();
        else if (led_index_i < LED_MAX) colour_store[led_index_i] = color_i;
      end
      if (out_valid_o && !out_stall_i) begin
        if (words_due.size() == 0) begin
          want = '0;
          note_mismatch(want, 1'b1);
        end else begin
          want = words_due.pop_front();
          if (want.word !== spi_word_o || want.last !== word_last_o ||
              want.blank !== reset_slot_o)
            note_mismatch(want, 1'b0);
        end
      end
      words_due_o = words_due.size();
    end
  end

endmodule

// ----- verif/addressable_led_spi_frame_encoder_test.sv -----
// top of the testbench for the addressable led spi frame encoder
// depends on alsfe_pkg, the block and alsfe_frame_checker; drives words and gives the verdict
`timescale 1ns / 1ps

module addressable_led_spi_frame_encoder_test;
  import alsfe_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 206;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic                   req_type_i   = 1'b0;
  logic [LED_INDEX_W-1:0] led_index_i  = '0;
  logic [COLOR_W-1:0]     color_i      = '0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic [SPI_WORD_W-1:0]  spi_word_o;
  logic                   word_last_o;
  logic                   reset_slot_o;

  int unsigned mismatch_cnt;
  int unsigned words_due;
  int unsigned items_sent   = 0;
  int unsigned words_taken  = 0;
  int unsigned cycle_cnt    = 0;
  logic        word_taken   = 1'b0;
  logic        rx_hold      = 1'b0;
  int unsigned rx_wait      = 0;

  addressable_led_spi_frame_encoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .led_index_i  (led_index_i),
    .color_i      (color_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .spi_word_o   (spi_word_o),
    .word_last_o  (word_last_o),
    .reset_slot_o (reset_slot_o)
  );

  alsfe_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .led_index_i    (led_index_i),
    .color_i        (color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .spi_word_o     (spi_word_o),
    .word_last_o    (word_last_o),
    .reset_slot_o   (reset_slot_o),
    .mismatch_cnt_o (mismatch_cnt),
    .words_due_o    (words_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // sender gap per word, with stretches of back-to-back words
  task automatic send_word(input req_type_e req, input logic [LED_INDEX_W-1:0] idx,
                           input logic [COLOR_W-1:0] colour);
    int unsigned gap;
    gap = ((items_sent / 30) % 3 == 1) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    led_index_i <= idx;
    color_i     <= colour;
    do @(posedge clk_i); while (in_stall_o);
    items_sent = items_sent + 1;
    @(negedge clk_i);
  endtask

  function automatic logic [COLOR_W-1:0] pick_colour();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes of index and colour, black led, then reset slots into the top leds
    send_word(REQ_WRITE, 6'd63, 24'hFFFFFF);
    send_word(REQ_WRITE, 6'd62, 24'h000000);
    send_word(REQ_WRITE, 6'd61, 24'hA5C33C);
    send_word(REQ_WRITE, 6'd60, 24'h800001);
    send_word(REQ_WRITE, 6'd0, 24'h123456);
    repeat (RESET_SLOTS + 4)
      send_word(REQ_REFILL, LED_INDEX_W'($urandom), COLOR_W'($urandom));

    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 45)
        send_word(REQ_WRITE, LED_INDEX_W'($urandom), pick_colour());
      else
        send_word(REQ_REFILL, LED_INDEX_W'($urandom), COLOR_W'($urandom));
    end
    in_valid_i <= 1'b0;

    while (words_due != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatch_cnt == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    int unsigned held;
    held = 0;
    wait (items_sent >= 60);
    @(negedge clk_i);
    rx_hold = 1'b1;
    while (held < HOLD_CYCLES) begin
      @(negedge clk_i);
      held = held + 1;
    end
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    word_taken <= out_valid_o && !out_stall_i;
    if (out_valid_o && !out_stall_i) words_taken <= words_taken + 1;
  end

  // receiver stall per word, with stretches of no stall at all
  always @(negedge clk_i) begin
    int unsigned draw;
    if (rx_hold) begin
      out_stall_i <= 1'b1;
    end else if (word_taken) begin
      draw = ((words_taken / 60) % 3 == 1) ? 0 : $urandom_range(0, 19);
      out_stall_i <= (draw != 0);
      rx_wait = (draw != 0) ? draw - 1 : 0;
    end else if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

endmodule

// ----- filelist.f -----
design/alsfe_pkg.sv
design/alsfe_ram.sv
design/alsfe_frame_ser.sv
design/addressable_led_spi_frame_encoder.sv
verif/alsfe_frame_checker.sv
verif/addressable_led_spi_frame_encoder_test.sv
